### src/ux6502_pkg.sv
package ux6502_pkg;

   // Opcode codes as carried in the opcode field
   typedef enum logic [4:0] {
      OP_LAX = 5'd0,
      OP_SAX = 5'd1,
      OP_DCP = 5'd2,
      OP_ISB = 5'd3,
      OP_SLO = 5'd4,
      OP_RLA = 5'd5,
      OP_SRE = 5'd6,
      OP_RRA = 5'd7,
      OP_AAC = 5'd8,
      OP_ASR = 5'd9,
      OP_ARR = 5'd10,
      OP_ATX = 5'd11,
      OP_AXS = 5'd12,
      OP_SYA = 5'd13,
      OP_SXA = 5'd14,
      OP_LAR = 5'd15,
      OP_AXA = 5'd16,
      OP_XAS = 5'd17,
      OP_XAA = 5'd18
   } op_type;

   localparam logic [7:0] XAA_MAGIC = 8'hEE;
   localparam logic [7:0] AXA_MASK  = 8'h07;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [7:0]  mem_data;
      logic [15:0] eff_addr;
      logic [7:0]  base_low;
      logic [7:0]  a_in;
      logic [7:0]  x_in;
      logic [7:0]  y_in;
      logic [7:0]  sp_in;
      logic        carry_in;
      logic        overflow_in;
      logic        negative_in;
      logic        zero_in;
   } req_type;

   typedef struct packed {
      logic [7:0] a_out;
      logic [7:0] x_out;
      logic [7:0] sp_out;
      logic       carry_out;
      logic       overflow_out;
      logic       negative_out;
      logic       zero_out;
      logic       write_enable;
      logic [7:0] write_data;
   } rsp_type;

endpackage

### src/ux6502_alu.sv
module ux6502_alu
   import ux6502_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0] m, a, x, y, hi, hi_inc;
   logic       c;
   logic [7:0] dec_m, inc_m, and_ax, and_am, rra_t, arr_a, res;
   logic [8:0] dcp_diff, isb_diff, rra_sum, axs_diff, sya_sum, sxa_sum;

   assign m      = req.mem_data;
   assign a      = req.a_in;
   assign x      = req.x_in;
   assign y      = req.y_in;
   assign c      = req.carry_in;
   assign hi     = req.eff_addr[15:8];
   assign hi_inc = hi + 8'd1;

   assign dec_m    = m - 8'd1;
   assign inc_m    = m + 8'd1;
   assign and_ax   = a & x;
   assign and_am   = a & m;
   assign rra_t    = {c, m[7:1]};
   assign arr_a    = {c, and_am[7:1]};
   assign dcp_diff = {1'b0, a} - {1'b0, dec_m};
   // borrow-in is the complement of carry
   assign isb_diff = {1'b0, a} - {1'b0, inc_m} - {8'd0, ~c};
   assign rra_sum  = {1'b0, a} + {1'b0, rra_t} + {8'd0, m[0]};
   assign axs_diff = {1'b0, and_ax} - {1'b0, m};
   assign sya_sum  = {1'b0, x} + {1'b0, req.base_low};
   assign sxa_sum  = {1'b0, y} + {1'b0, req.base_low};

   always_comb begin
      rsp.a_out        = a;
      rsp.x_out        = x;
      rsp.sp_out       = req.sp_in;
      rsp.carry_out    = c;
      rsp.overflow_out = req.overflow_in;
      rsp.negative_out = req.negative_in;
      rsp.zero_out     = req.zero_in;
      rsp.write_enable = 1'b0;
      rsp.write_data   = 8'd0;
      res              = 8'd0;
      case (req.opcode)
         OP_LAX, OP_ATX: begin
            rsp.a_out = m;
            rsp.x_out = m;
            res       = m;
         end
         OP_SAX: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = and_ax;
         end
         OP_DCP: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = dec_m;
            rsp.carry_out    = ~dcp_diff[8];
            res              = dcp_diff[7:0];
         end
         OP_ISB: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = inc_m;
            rsp.carry_out    = ~isb_diff[8];
            rsp.overflow_out = (a[7] ^ inc_m[7]) & (a[7] ^ isb_diff[7]);
            rsp.a_out        = isb_diff[7:0];
            res              = isb_diff[7:0];
         end
         OP_SLO: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = {m[6:0], 1'b0};
            rsp.carry_out    = m[7];
            rsp.a_out        = a | {m[6:0], 1'b0};
            res              = a | {m[6:0], 1'b0};
         end
         OP_RLA: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = {m[6:0], c};
            rsp.carry_out    = m[7];
            rsp.a_out        = a & {m[6:0], c};
            res              = a & {m[6:0], c};
         end
         OP_SRE: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = {1'b0, m[7:1]};
            rsp.carry_out    = m[0];
            rsp.a_out        = a ^ {1'b0, m[7:1]};
            res              = a ^ {1'b0, m[7:1]};
         end
         OP_RRA: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = rra_t;
            rsp.carry_out    = rra_sum[8];
            rsp.overflow_out = (a[7] ^ rra_sum[7]) & (rra_t[7] ^ rra_sum[7]);
            rsp.a_out        = rra_sum[7:0];
            res              = rra_sum[7:0];
         end
         OP_AAC: begin
            rsp.a_out     = and_am;
            rsp.carry_out = and_am[7];
            res           = and_am;
         end
         OP_ASR: begin
            rsp.carry_out = and_am[0];
            rsp.a_out     = {1'b0, and_am[7:1]};
            res           = {1'b0, and_am[7:1]};
         end
         OP_ARR: begin
            rsp.a_out        = arr_a;
            rsp.carry_out    = arr_a[6];
            rsp.overflow_out = arr_a[6] ^ arr_a[5];
            res              = arr_a;
         end
         OP_AXS: begin
            rsp.carry_out = ~axs_diff[8];
            rsp.x_out     = axs_diff[7:0];
            res           = axs_diff[7:0];
         end
         OP_SYA: begin
            // store only when indexing stays in the page
            if (!sya_sum[8]) begin
               rsp.write_enable = 1'b1;
               rsp.write_data   = y & hi_inc;
            end
         end
         OP_SXA: begin
            if (!sxa_sum[8]) begin
               rsp.write_enable = 1'b1;
               rsp.write_data   = x & hi_inc;
            end
         end
         OP_LAR: begin
            // flags untouched
            rsp.a_out  = m & req.sp_in;
            rsp.x_out  = m & req.sp_in;
            rsp.sp_out = m & req.sp_in;
         end
         OP_AXA: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = and_ax & AXA_MASK;
         end
         OP_XAS: begin
            rsp.sp_out       = and_ax;
            rsp.write_enable = 1'b1;
            rsp.write_data   = and_ax & hi;
         end
         OP_XAA: begin
            rsp.a_out = (a | XAA_MAGIC) & x & m;
            res       = (a | XAA_MAGIC) & x & m;
         end
         default: begin
         end
      endcase
      // N/Z follow the result byte on opcodes that update them
      case (req.opcode)
         OP_LAX, OP_ATX, OP_DCP, OP_ISB, OP_SLO, OP_RLA, OP_SRE, OP_RRA,
         OP_AAC, OP_ASR, OP_ARR, OP_AXS, OP_XAA: begin
            rsp.negative_out = res[7];
            rsp.zero_out     = (res == 8'd0);
         end
         default: begin
         end
      endcase
   end

endmodule

### src/undocumented_6502_execute.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data (req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data (rsp_type)
//
// One transaction per cycle sustained while rsp_ready stays high; a req passes
// the input register, then the ALU into the result register, before rsp_valid.
// Throughput is set by the single ALU pass between the two registers.
// Synchronous active-high reset clears both valid flags only.
// A stalled rsp holds its data; req_ready drops only when both stages are
// full and rsp_ready is low.
module undocumented_6502_execute
   import ux6502_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;
   rsp_type alu_rsp;
   logic    out_take;   // result register loads this cycle
   logic    in_take;    // input register loads this cycle

   ux6502_alu u_alu (
      .req (in_data_ff),
      .rsp (alu_rsp)
   );

   // result stage can load when empty or draining
   assign out_take  = in_vld_ff & (~out_vld_ff | rsp_ready);
   // input stage frees when empty or moving forward
   assign req_ready = ~in_vld_ff | ~out_vld_ff | rsp_ready;
   assign in_take   = req_valid & req_ready;

   assign in_vld_in  = in_take | (in_vld_ff & ~out_take);
   assign out_vld_in = out_take | (out_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_take) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

### src/ux6502_checker.sv
module ux6502_checker
   import ux6502_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // empty output stage never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req blocked with empty output");

   // accepted transaction reaches the result register when not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("rsp missing after accepted req");

   a_wdata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |-> rsp_data.write_data == 8'd0)
      else $error("write_data set without write_enable");

endmodule

bind undocumented_6502_execute ux6502_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import ux6502_pkg::*;
();

   // Timing
   localparam int CLK_HALF      = 4;        // 8 ns period
   localparam int RESET_CYCLES  = 11;
   localparam int DRAIN_CYCLES  = 8;        // two-stage pipe, plus margin
   localparam int HOLD_CYCLES   = 150;      // long receiver back-pressure
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;

   // Opcode values past the last defined one must pass everything through
   localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
   localparam logic [4:0] OP_LAST_CODE    = 5'd31;

   // Flag nibble order used by the item builder: {C, V, N, Z}
   localparam logic [3:0] FLAGS_CLEAR = 4'b0000;
   localparam logic [3:0] FLAGS_SET   = 4'b1111;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Expected results, oldest first
   rsp_type pending_results[$];

   int   error_count   = 0;
   int   cycle_count   = 0;
   logic idle_on       = 1'b1;   // random bubbles on both channels
   logic rsp_hold      = 1'b0;   // receiver held off by the long stall
   int   stall_left    = 0;
   event hold_start;

   undocumented_6502_execute dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: what the execute stage should produce for one instruction.
   // Starts from a full pass-through, then each opcode overrides only the
   // registers and flags it touches.
   // ------------------------------------------------------------------
   function automatic rsp_type exec_undoc(input req_type r);
      rsp_type    o;
      logic [7:0] a, x, sp, t, res, hi, nz_val;
      logic       c, v, nz_upd;
      logic [8:0] sum;
      a      = r.a_in;
      x      = r.x_in;
      sp     = r.sp_in;
      c      = r.carry_in;
      v      = r.overflow_in;
      hi     = r.eff_addr[15:8];
      nz_upd = 1'b0;
      nz_val = '0;
      o      = '0;
      o.negative_out = r.negative_in;
      o.zero_out     = r.zero_in;
      case (r.opcode)
         OP_LAX, OP_ATX: begin
            a = r.mem_data;
            x = r.mem_data;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_SAX: begin
            o.write_enable = 1'b1;
            o.write_data   = r.a_in & r.x_in;
         end
         OP_DCP: begin
            t = r.mem_data - 8'd1;
            o.write_enable = 1'b1;
            o.write_data   = t;
            c = (a >= t);
            nz_upd = 1'b1; nz_val = a - t;
         end
         OP_ISB: begin
            // increment then subtract with borrow; carry means no borrow
            t   = r.mem_data + 8'd1;
            o.write_enable = 1'b1;
            o.write_data   = t;
            sum = {1'b0, a} - {1'b0, t} - {8'd0, ~c};
            res = sum[7:0];
            c   = ~sum[8];
            v   = (a[7] ^ t[7]) & (a[7] ^ res[7]);
            a   = res;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_SLO: begin
            c = r.mem_data[7];
            t = {r.mem_data[6:0], 1'b0};
            o.write_enable = 1'b1;
            o.write_data   = t;
            a = a | t;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_RLA: begin
            t = {r.mem_data[6:0], c};
            c = r.mem_data[7];
            o.write_enable = 1'b1;
            o.write_data   = t;
            a = a & t;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_SRE: begin
            c = r.mem_data[0];
            t = {1'b0, r.mem_data[7:1]};
            o.write_enable = 1'b1;
            o.write_data   = t;
            a = a ^ t;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_RRA: begin
            // rotate right through carry, then add with the carry shifted out
            t   = {c, r.mem_data[7:1]};
            o.write_enable = 1'b1;
            o.write_data   = t;
            sum = {1'b0, a} + {1'b0, t} + {8'd0, r.mem_data[0]};
            res = sum[7:0];
            c   = sum[8];
            v   = (a[7] ^ res[7]) & (t[7] ^ res[7]);
            a   = res;
            nz_upd = 1'b1; nz_val = a;
         end
         OP_AAC: begin
            a = a & r.mem_data;
            c = a[7];   // carry copies the new negative flag
            nz_upd = 1'b1; nz_val = a;
         end
         OP_ASR: begin
            t = a & r.mem_data;
            c = t[0];
            a = {1'b0, t[7:1]};
            nz_upd = 1'b1; nz_val = a;
         end
         OP_ARR: begin
            t = a & r.mem_data;
            a = {c, t[7:1]};
            c = a[6];
            v = a[5] ^ a[6];
            nz_upd = 1'b1; nz_val = a;
         end
         OP_AXS: begin
            t = x & a;
            c = (t >= r.mem_data);
            x = t - r.mem_data;
            nz_upd = 1'b1; nz_val = x;
         end
         OP_SYA: begin
            // store only when the indexed low byte does not cross a page
            sum = {1'b0, r.x_in} + {1'b0, r.base_low};
            if (!sum[8]) begin
               o.write_enable = 1'b1;
               o.write_data   = r.y_in & (hi + 8'd1);
            end
         end
         OP_SXA: begin
            sum = {1'b0, r.y_in} + {1'b0, r.base_low};
            if (!sum[8]) begin
               o.write_enable = 1'b1;
               o.write_data   = r.x_in & (hi + 8'd1);
            end
         end
         OP_LAR: begin
            // flags stay as they were
            t  = r.mem_data & sp;
            a  = t;
            x  = t;
            sp = t;
         end
         OP_AXA: begin
            o.write_enable = 1'b1;
            o.write_data   = r.a_in & r.x_in & AXA_MASK;
         end
         OP_XAS: begin
            sp = r.a_in & r.x_in;
            o.write_enable = 1'b1;
            o.write_data   = sp & hi;
         end
         OP_XAA: begin
            a = (a | XAA_MAGIC) & r.x_in & r.mem_data;
            nz_upd = 1'b1; nz_val = a;
         end
         default: ;   // unused codes: no change, no write
      endcase
      o.a_out        = a;
      o.x_out        = x;
      o.sp_out       = sp;
      o.carry_out    = c;
      o.overflow_out = v;
      if (nz_upd) begin
         o.negative_out = nz_val[7];
         o.zero_out     = (nz_val == 8'd0);
      end
      return o;
   endfunction

   function automatic req_type make_instr(input logic [4:0] code, input logic [7:0] m,
                                          input logic [15:0] ea, input logic [7:0] bl,
                                          input logic [7:0] a, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] sp,
                                          input logic [3:0] flags);
      req_type r;
      r.opcode      = op_type'(code);
      r.mem_data    = m;
      r.eff_addr    = ea;
      r.base_low    = bl;
      r.a_in        = a;
      r.x_in        = x;
      r.y_in        = y;
      r.sp_in       = sp;
      r.carry_in    = flags[3];
      r.overflow_in = flags[2];
      r.negative_in = flags[1];
      r.zero_in     = flags[0];
      return r;
   endfunction

   // Bytes lean toward the corners that matter for carry, sign and zero
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type rand_instr();
      logic [4:0] code;
      logic [7:0] idx;
      req_type    r;
      if ($urandom_range(0, 49) == 0)
         code = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      else
         code = 5'($urandom_range(OP_LAX, OP_XAA));
      r = make_instr(code, pick_byte(), 16'($urandom), pick_byte(), pick_byte(),
                     pick_byte(), pick_byte(), pick_byte(), 4'($urandom));
      // Often put the indexed sum right at the page edge for SYA/SXA
      if ((r.opcode == OP_SYA || r.opcode == OP_SXA) && $urandom_range(0, 1)) begin
         idx = (r.opcode == OP_SYA) ? r.x_in : r.y_in;
         r.base_low = 8'hFF - idx + 8'($urandom_range(0, 1));
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side: one transaction, optionally preceded by an idle burst.
   // Called at a rising edge; returns at the edge the item is taken.
   // ------------------------------------------------------------------
   task automatic issue_instr(input req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(exec_undoc(r));
   endtask

   // Sender goes quiet until everything in flight has come back
   task automatic wait_all_retired();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts, plus a long hold when asked.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long hold-off, counted here so the sender keeps running meanwhile
   always begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     name, cycle_count, want, got);
      end
   endtask

   // Scoreboard: every accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response at cycle %0d: %p", cycle_count, rsp_data);
         end else begin
            want = pending_results.pop_front();
            compare_field("a_out",        rsp_data.a_out,        want.a_out);
            compare_field("x_out",        rsp_data.x_out,        want.x_out);
            compare_field("sp_out",       rsp_data.sp_out,       want.sp_out);
            compare_field("carry_out",    8'(rsp_data.carry_out),    8'(want.carry_out));
            compare_field("overflow_out", 8'(rsp_data.overflow_out), 8'(want.overflow_out));
            compare_field("negative_out", 8'(rsp_data.negative_out), 8'(want.negative_out));
            compare_field("zero_out",     8'(rsp_data.zero_out),     8'(want.zero_out));
            compare_field("write_enable", 8'(rsp_data.write_enable), 8'(want.write_enable));
            compare_field("write_data",   rsp_data.write_data,   want.write_data);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // One of each opcode, operands at the corners
   task automatic test_each_opcode();
      issue_instr(make_instr(OP_LAX, 8'h00, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_SAX, 8'hFF, 16'hFFFF, 8'hFF, 8'hF0, 8'h3C, 8'hFF, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_DCP, 8'h00, 16'h1234, 8'h34, 8'hFF, 8'h00, 8'h00, 8'hFD,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_ISB, 8'hFF, 16'h8000, 8'h00, 8'h7F, 8'h00, 8'h00, 8'hFF,
                             FLAGS_SET));
      issue_instr(make_instr(OP_SLO, 8'h80, 16'h00FF, 8'hFF, 8'h00, 8'h55, 8'h00, 8'h80,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_RLA, 8'hFF, 16'h4000, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_SRE, 8'h01, 16'h0200, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_RRA, 8'hFF, 16'hC000, 8'h00, 8'h7F, 8'h00, 8'h00, 8'hFF,
                             FLAGS_SET));
      issue_instr(make_instr(OP_AAC, 8'hFF, 16'h0000, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_ASR, 8'h01, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_ARR, 8'hFF, 16'h0000, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_ATX, 8'h80, 16'h5555, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_AXS, 8'hFF, 16'hAAAA, 8'hAA, 8'h0F, 8'hFF, 8'h00, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_SYA, 8'h00, 16'h7F10, 8'h10, 8'h00, 8'h20, 8'hFF, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_SXA, 8'h00, 16'h3F10, 8'h10, 8'h00, 8'hFF, 8'h20, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_LAR, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_AXA, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_XAS, 8'h00, 16'hF0FF, 8'hFF, 8'hFF, 8'h3C, 8'h00, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_XAA, 8'hFF, 16'h0000, 8'h00, 8'h11, 8'hFF, 8'h00, 8'h00,
                             FLAGS_SET));
   endtask

   // Page-cross tests, borrow/carry corners, LAR flags, unused opcodes
   task automatic test_special_cases();
      // SYA: x + base_low = 0xFF stores, high+1 wraps to zero
      issue_instr(make_instr(OP_SYA, 8'h00, 16'hFFFF, 8'hF0, 8'h00, 8'h0F, 8'hFF, 8'h00,
                             FLAGS_CLEAR));
      // SYA: x + base_low = 0x100 crosses the page, no store
      issue_instr(make_instr(OP_SYA, 8'h00, 16'h1234, 8'hF1, 8'h00, 8'h0F, 8'hFF, 8'h00,
                             FLAGS_CLEAR));
      issue_instr(make_instr(OP_SXA, 8'h00, 16'hFE00, 8'h01, 8'h00, 8'hFF, 8'hFE, 8'h00,
                             FLAGS_SET));
      issue_instr(make_instr(OP_SXA, 8'h00, 16'hFE00, 8'h02, 8'h00, 8'hFF, 8'hFE, 8'h00,
                             FLAGS_SET));
      // ISB with borrow in and equal operands: result goes negative
      issue_instr(make_instr(OP_ISB, 8'h0F, 16'h0000, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00,
                             FLAGS_CLEAR));
      // LAR leaves all flags alone even when the result is zero
      issue_instr(make_instr(OP_LAR, 8'h0F, 16'h0000, 8'h00, 8'h12, 8'h34, 8'h56, 8'hF0,
                             4'b0101));
      issue_instr(make_instr(OP_FIRST_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 8'h12, 8'h34, 8'h56,
                             8'h78, 4'b1010));
      issue_instr(make_instr(OP_LAST_CODE, 8'hA5, 16'h5A5A, 8'h00, 8'hFF, 8'h00, 8'hFF,
                             8'h00, FLAGS_SET));
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) issue_instr(rand_instr());
   endtask

   // Receiver stalls for a long stretch while requests keep coming, so the
   // pipe fills and req_ready drops; then the sender waits for a full drain.
   task automatic test_backpressure();
      -> hold_start;
      repeat (60) issue_instr(rand_instr());
      wait_all_retired();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_each_opcode();
      test_special_cases();
      wait_all_retired();

      test_random_traffic(600);
      idle_on <= 1'b0;          // a stretch with no bubbles at all
      test_random_traffic(200);
      idle_on <= 1'b1;
      test_random_traffic(200);
      test_backpressure();

      idle_on <= 1'b0;          // closing part runs flat out
      test_random_traffic(400);
      wait_all_retired();

      if (error_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
